// ===== sv/vfmc_pkg.sv =====
// Shared types, constants and helper functions for the viscous face metric coefficient block.
`timescale 1ns / 1ps
package vfmc_pkg;

  // Field and datapath widths.
  localparam int FW   = 32;        // width of one Q16.16 field
  localparam int NC   = 9;         // number of coefficients per face
  localparam int NP   = 10;        // number of distinct metric products
  localparam int SW   = FW + 1;    // pair sum width
  localparam int PW   = 2 * SW;    // product width
  localparam int QW   = PW + 3;    // weighted sum width (weights up to 4 in magnitude)
  localparam int DW   = SW + 3;    // divisor width, six times the Jacobian sum magnitude
  localparam int RB   = FW - 1;    // quotient bits kept below the saturation limit
  localparam int BITS_PER_STAGE = 2;

  // Face direction codes.
  typedef enum logic {
    OP_XI  = 1'b0,
    OP_ETA = 1'b1
  } op_t;

  // Saturation limits.
  localparam logic [FW-1:0] SAT_POS = {1'b0, {(FW-1){1'b1}}};
  localparam logic [FW-1:0] SAT_NEG = {1'b1, {(FW-1){1'b0}}};

  // Product order: aa, bb, cc, dd, ab, ac, ad, bc, bd, cd.
  // Each entry: first product, first weight, second product, second weight.
  localparam int COEF_TAB [2][NC][4] = '{
    '{ '{2, 3, 3, 4}, '{5, -3, 8, -4}, '{7, 3, 6, -2},
       '{6, 3, 7, -2}, '{3, 3, 2, 4}, '{8, -3, 5, -4},
       '{9, -1, 9, 0}, '{3, 3, 2, 3}, '{8, -3, 5, -3} },
    '{ '{5, -3, 8, -4}, '{0, 3, 1, 4}, '{6, 3, 7, -2},
       '{7, 3, 6, -2}, '{8, -3, 5, -4}, '{1, 3, 0, 4},
       '{4, -1, 4, 0}, '{8, -3, 5, -3}, '{1, 3, 0, 3} }
  };

  // One division lane: partial remainder and the shift word that turns
  // from dividend bits into quotient bits.
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [RB-1:0] work;
  } lane_t;

  // Everything that travels through the division stages for one transaction.
  typedef struct packed {
    logic             zero;
    logic [DW-1:0]    dvs;
    logic [NC-1:0]    neg;
    logic [NC-1:0]    sat;
    lane_t [NC-1:0]   lane;
  } dstage_t;

  // Multiply a product by a small signed weight with shifts and adds.
  function automatic logic signed [QW-1:0] scale(input logic signed [PW-1:0] p,
                                                 input logic signed [3:0] w);
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] m;
    logic signed [3:0]    nw;
    logic [2:0]           mag;
    x   = QW'(p);
    nw  = -w;
    mag = w[3] ? nw[2:0] : w[2:0];
    case (mag)
      3'd1:    m = x;
      3'd2:    m = x <<< 1;
      3'd3:    m = x + (x <<< 1);
      3'd4:    m = x <<< 2;
      default: m = '0;
    endcase
    scale = w[3] ? -m : m;
  endfunction

endpackage

// ===== sv/vfmc_front.sv =====
// Front stages: pair sums, metric products, weighted sums and magnitudes.
`timescale 1ns / 1ps
module vfmc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic                       op,
  input  logic [10*vfmc_pkg::FW-1:0] fields,
  output logic                       out_valid,
  output vfmc_pkg::dstage_t          out_item
);

  localparam int FW = vfmc_pkg::FW;
  localparam int SW = vfmc_pkg::SW;
  localparam int PW = vfmc_pkg::PW;
  localparam int QW = vfmc_pkg::QW;
  localparam int DW = vfmc_pkg::DW;
  localparam int NC = vfmc_pkg::NC;
  localparam int NP = vfmc_pkg::NP;
  localparam int RB = vfmc_pkg::RB;

  // Stage 1: pair sums of the five metrics.
  logic signed [SW-1:0] sum_nxt [5];
  logic signed [SW-1:0] sum_r   [5];
  logic                 op1_r;
  logic                 v1_r;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      sum_nxt[i] = {fields[FW*i+FW-1], fields[FW*i +: FW]}
                 + {fields[FW*(i+5)+FW-1], fields[FW*(i+5) +: FW]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
      op1_r <= op;
    end
  end

  // Stage 2: the ten products, divisor and zero flag.
  logic signed [PW-1:0] prod_nxt [NP];
  logic signed [PW-1:0] prod_r   [NP];
  logic [SW-1:0]        smag;
  logic [DW-1:0]        dvs_nxt;
  logic [DW-1:0]        dvs2_r;
  logic                 zero2_r;
  logic                 sneg2_r;
  logic                 op2_r;
  logic                 v2_r;

  always_comb begin
    prod_nxt[0] = sum_r[0] * sum_r[0];
    prod_nxt[1] = sum_r[1] * sum_r[1];
    prod_nxt[2] = sum_r[2] * sum_r[2];
    prod_nxt[3] = sum_r[3] * sum_r[3];
    prod_nxt[4] = sum_r[0] * sum_r[1];
    prod_nxt[5] = sum_r[0] * sum_r[2];
    prod_nxt[6] = sum_r[0] * sum_r[3];
    prod_nxt[7] = sum_r[1] * sum_r[2];
    prod_nxt[8] = sum_r[1] * sum_r[3];
    prod_nxt[9] = sum_r[2] * sum_r[3];
    smag        = sum_r[4][SW-1] ? SW'(-sum_r[4]) : SW'(sum_r[4]);
    dvs_nxt     = (DW'(smag) << 2) + (DW'(smag) << 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      dvs2_r  <= dvs_nxt;
      zero2_r <= (sum_r[4] == '0);
      sneg2_r <= sum_r[4][SW-1];
      op2_r   <= op1_r;
    end
  end

  // Stage 3: weighted sum of two products per coefficient.
  logic signed [QW-1:0] q_nxt [NC];
  logic signed [QW-1:0] q_r   [NC];
  logic [DW-1:0]        dvs3_r;
  logic                 zero3_r;
  logic                 sneg3_r;
  logic                 v3_r;

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      if (op2_r == vfmc_pkg::OP_ETA) begin
        q_nxt[k] = vfmc_pkg::scale(prod_r[4'(vfmc_pkg::COEF_TAB[1][k][0])],
                                   4'(vfmc_pkg::COEF_TAB[1][k][1]))
                 + vfmc_pkg::scale(prod_r[4'(vfmc_pkg::COEF_TAB[1][k][2])],
                                   4'(vfmc_pkg::COEF_TAB[1][k][3]));
      end else begin
        q_nxt[k] = vfmc_pkg::scale(prod_r[4'(vfmc_pkg::COEF_TAB[0][k][0])],
                                   4'(vfmc_pkg::COEF_TAB[0][k][1]))
                 + vfmc_pkg::scale(prod_r[4'(vfmc_pkg::COEF_TAB[0][k][2])],
                                   4'(vfmc_pkg::COEF_TAB[0][k][3]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r     <= q_nxt;
      dvs3_r  <= dvs2_r;
      zero3_r <= zero2_r;
      sneg3_r <= sneg2_r;
    end
  end

  // Stage 4: magnitude, result sign, saturation test and lane start values.
  // A quotient at or above 2^31 saturates for either sign.
  vfmc_pkg::dstage_t item_nxt;
  vfmc_pkg::dstage_t item_r;
  logic              v4_r;
  logic [QW-1:0]     mag;
  logic [QW-1:0]     limit;

  always_comb begin
    item_nxt.zero = zero3_r;
    item_nxt.dvs  = dvs3_r;
    limit         = QW'({dvs3_r, {RB{1'b0}}});
    for (int k = 0; k < NC; k++) begin
      mag                    = q_r[k][QW-1] ? QW'(-q_r[k]) : QW'(q_r[k]);
      item_nxt.neg[k]        = q_r[k][QW-1] ^ sneg3_r;
      item_nxt.sat[k]        = (mag >= limit);
      item_nxt.lane[k].rem   = item_nxt.sat[k] ? '0 : mag[RB +: DW];
      item_nxt.lane[k].work  = mag[RB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_item  = item_r;

endmodule

// ===== sv/vfmc_div_stage.sv =====
// One registered stage of the restoring divider, STEPS quotient bits per lane.
`timescale 1ns / 1ps
module vfmc_div_stage #(
  parameter int STEPS = vfmc_pkg::BITS_PER_STAGE
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  vfmc_pkg::dstage_t in_item,
  output logic              out_valid,
  output vfmc_pkg::dstage_t out_item
);

  localparam int DW = vfmc_pkg::DW;
  localparam int RB = vfmc_pkg::RB;
  localparam int NC = vfmc_pkg::NC;

  vfmc_pkg::dstage_t item_nxt;
  vfmc_pkg::dstage_t item_r;
  logic              v_r;

  // Shift in the next dividend bit, subtract the divisor where it fits.
  always_comb begin
    logic [DW:0] rem2;
    logic        qb;
    item_nxt = in_item;
    for (int s = 0; s < STEPS; s++) begin
      for (int l = 0; l < NC; l++) begin
        rem2 = {item_nxt.lane[l].rem, item_nxt.lane[l].work[RB-1]};
        qb   = (rem2 >= {1'b0, item_nxt.dvs});
        if (qb) begin
          rem2 = rem2 - {1'b0, item_nxt.dvs};
        end
        item_nxt.lane[l].rem  = rem2[DW-1:0];
        item_nxt.lane[l].work = {item_nxt.lane[l].work[RB-2:0], qb};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_item  = item_r;

endmodule

// ===== sv/viscous_face_metric_coefficients_top.sv =====
// Top level of the viscous face metric coefficient pipeline.
`timescale 1ns / 1ps
// Takes one face record per cycle and returns one transaction of nine saturated Q16.16
// coefficients per record, in order. It is 4 front stages plus ceil(31 / BITS_PER_STAGE)
// divider stages plus one output register. The rate is one transaction per cycle; the whole
// pipeline holds while a finished result waits on out_tready. The length of the pipeline is set
// by the restoring divider that forms each coefficient as a weighted product sum over six times
// the Jacobian sum. A zero Jacobian sum gives all-zero coefficients with out_tuser set.
module viscous_face_metric_coefficients_top #(
  parameter int BITS_PER_STAGE = vfmc_pkg::BITS_PER_STAGE
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // Fields from bit 0: left_x_xi, left_y_xi, left_x_eta, left_y_eta, left_jacobian,
  // right_x_xi, right_y_xi, right_x_eta, right_y_eta, right_jacobian.
  input  logic [319:0] in_tdata,
  // Fields from bit 0: operation.
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // Fields from bit 0: coef_u1, coef_u2, coef_u3, coef_v1, coef_v2, coef_v3,
  // coef_uv, coef_e1, coef_e2.
  output logic [287:0] out_tdata,
  // Fields from bit 0: jacobian_zero.
  output logic         out_tuser
);

  localparam int FW   = vfmc_pkg::FW;
  localparam int NC   = vfmc_pkg::NC;
  localparam int RB   = vfmc_pkg::RB;
  localparam int NDIV = (RB + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

  logic en;
  logic out_valid_r;
  logic [NC*FW-1:0] out_data_r;
  logic [NC*FW-1:0] out_data_nxt;
  logic out_zero_r;

  // The pipeline moves whenever the output register is free or being emptied.
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Front stages.
  logic              fv;
  vfmc_pkg::dstage_t fitem;

  vfmc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .op        (in_tuser),
    .fields    (in_tdata),
    .out_valid (fv),
    .out_item  (fitem)
  );

  // Divider chain.
  logic              dv    [NDIV+1];
  vfmc_pkg::dstage_t ditem [NDIV+1];

  assign dv[0]    = fv;
  assign ditem[0] = fitem;

  for (genvar i = 0; i < NDIV; i++) begin : g_div
    localparam int ST = (RB - BITS_PER_STAGE * i >= BITS_PER_STAGE)
                        ? BITS_PER_STAGE : (RB - BITS_PER_STAGE * i);
    vfmc_div_stage #(.STEPS(ST)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (dv[i]),
      .in_item   (ditem[i]),
      .out_valid (dv[i+1]),
      .out_item  (ditem[i+1])
    );
  end

  // Sign, saturation and the zero Jacobian case.
  always_comb begin
    logic [FW-1:0] qv;
    for (int k = 0; k < NC; k++) begin
      qv = {1'b0, ditem[NDIV].lane[k].work};
      if (ditem[NDIV].zero) begin
        out_data_nxt[FW*k +: FW] = '0;
      end else if (ditem[NDIV].neg[k]) begin
        out_data_nxt[FW*k +: FW] = ditem[NDIV].sat[k] ? vfmc_pkg::SAT_NEG : FW'(-qv);
      end else begin
        out_data_nxt[FW*k +: FW] = ditem[NDIV].sat[k] ? vfmc_pkg::SAT_POS : qv;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_zero_r <= ditem[NDIV].zero;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_zero_r;

  // A zero Jacobian sum always comes out with every coefficient cleared.
  a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("zero Jacobian result carries nonzero coefficients");

  // Input is taken exactly when the pipeline advances.
  a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready disagrees with output stall");

  // A held result does not change while the pipeline is stalled.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule
